// File: src/rssd_pkg.sv
package rssd_pkg;

    localparam logic [15:0] KEY_BLUE   = 16'h001F;
    localparam logic [15:0] KEY_GREEN  = 16'h07C0;
    localparam logic [15:0] EMPTY_LAST = 16'hFFFF;

    // Clears the low two bits after adding three: width rounded up to a multiple of 4.
    localparam logic [15:0] WIDTH_MASK = 16'hFFFC;
    localparam logic [15:0] WIDTH_PAD  = 16'd3;

    localparam int FIFO_DEPTH_DEF = 4;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register select is paddr[2].
    localparam logic REG_RAW_WIDTH = 1'b0;
    localparam logic REG_ROW_COUNT = 1'b1;

    typedef enum logic [1:0] {
        STAT_RUN   = 2'd0,
        STAT_DONE  = 2'd1,
        STAT_TRUNC = 2'd2
    } status_t;

    typedef struct packed {
        logic          write_enable;
        logic [16:0]   pixel_index;
        logic [15:0]   pixel_colour;
        status_t       status;
    } rssd_result_t;

endpackage

// File: src/rssd_front.sv
module rssd_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [15:0]           in_data_word,
    input  logic                  in_end_of_data,
    input  logic [15:0]           raw_width,
    input  logic [15:0]           row_count,
    input  logic                  q_full,
    output logic                  q_push,
    output rssd_pkg::rssd_result_t q_data
);
    import rssd_pkg::*;

    typedef enum logic [2:0] {
        PH_TRANS = 3'b001,
        PH_LAST  = 3'b010,
        PH_PIXEL = 3'b100
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic [15:0]  row_reg, row_next;
    logic [15:0]  base_reg, base_next;
    logic [16:0]  col_reg, col_next;
    logic [16:0]  left_reg, left_next;
    logic [15:0]  trans_reg, trans_next;

    logic         accept;
    logic         active;
    logic         finish;
    logic         we;
    logic [15:0]  eff_w;
    logic [16:0]  last_plus1;
    logic [16:0]  left_dec;
    logic         bad_hdr;

    assign in_ready   = !q_full;
    assign accept     = in_valid && in_ready;
    assign active     = row_reg < row_count;
    assign eff_w      = (raw_width + WIDTH_PAD) & WIDTH_MASK;
    assign last_plus1 = {1'b0, in_data_word} + 17'd1;
    assign left_dec   = left_reg - 17'd1;
    assign bad_hdr    = ((trans_reg == 16'd0) && (in_data_word == EMPTY_LAST))
                     || (trans_reg > eff_w)
                     || (trans_reg > in_data_word)
                     || (last_plus1 > {1'b0, eff_w});

    always_comb begin
        phase_next = phase_reg;
        row_next   = row_reg;
        base_next  = base_reg;
        col_next   = col_reg;
        left_next  = left_reg;
        trans_next = trans_reg;
        finish     = 1'b0;
        we         = 1'b0;
        if (accept && active) begin
            unique case (phase_reg)
                PH_LAST: begin
                    if (bad_hdr) begin
                        finish = 1'b1;
                    end else begin
                        col_next   = {1'b0, trans_reg};
                        left_next  = last_plus1 - {1'b0, trans_reg};
                        phase_next = PH_PIXEL;
                    end
                end
                PH_PIXEL: begin
                    we        = (in_data_word != KEY_BLUE) && (in_data_word != KEY_GREEN);
                    col_next  = col_reg + 17'd1;
                    left_next = left_dec;
                    finish    = (left_dec == 17'd0);
                end
                default: begin
                    trans_next = in_data_word;
                    phase_next = PH_LAST;
                end
            endcase
            if (finish) begin
                row_next   = row_reg + 16'd1;
                base_next  = base_reg + eff_w;
                phase_next = PH_TRANS;
                col_next   = '0;
                left_next  = '0;
            end
        end
        if (accept && in_end_of_data) begin
            phase_next = PH_TRANS;
            row_next   = '0;
            base_next  = '0;
            col_next   = '0;
            left_next  = '0;
            trans_next = '0;
        end
    end

    // Status looks at the row count after this beat's row has closed.
    always_comb begin
        q_push              = accept && (we || in_end_of_data);
        q_data.write_enable = we;
        q_data.pixel_index  = we ? ({1'b0, base_reg} + col_reg) : 17'd0;
        q_data.pixel_colour = we ? in_data_word : 16'd0;
        if (!in_end_of_data) begin
            q_data.status = STAT_RUN;
        end else if (accept && active && finish) begin
            q_data.status = ((row_reg + 16'd1) >= row_count) ? STAT_DONE : STAT_TRUNC;
        end else begin
            q_data.status = active ? STAT_TRUNC : STAT_DONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TRANS;
            row_reg   <= '0;
            base_reg  <= '0;
            col_reg   <= '0;
            left_reg  <= '0;
            trans_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
            base_reg  <= base_next;
            col_reg   <= col_next;
            left_reg  <= left_next;
            trans_reg <= trans_next;
        end
    end

endmodule

// File: src/rssd_fifo.sv
module rssd_fifo #(
    parameter int DEPTH = rssd_pkg::FIFO_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  rssd_pkg::rssd_result_t push_data,
    output logic                   full,
    input  logic                   pop,
    output logic                   not_empty,
    output rssd_pkg::rssd_result_t pop_data
);
    import rssd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    rssd_result_t      mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full      = (cnt_reg == FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= FULL_CNT)
        else $error("queue count above depth");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !not_empty |-> !pop)
        else $error("pop from empty queue");
    a_cnt_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count missed a push");
`endif

endmodule

// File: src/rssd_back.sv
module rssd_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_not_empty,
    input  rssd_pkg::rssd_result_t q_data,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output rssd_pkg::rssd_result_t out_data
);
    import rssd_pkg::*;

    logic         valid_reg, valid_next;
    rssd_result_t data_reg;

    assign q_pop      = q_not_empty && (!valid_reg || out_ready);
    assign valid_next = q_pop || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            data_reg <= q_data;
        end
    end

endmodule

// File: src/row_span_sprite_decoder_top.sv
// Channel   | Handshake               | Payload
// ----------+-------------------------+------------------------------------------------
// s_ (in)   | s_valid / s_ready       | s_data_word[15:0], s_end_of_data
// m_ (out)  | m_valid / m_ready       | m_write_enable, m_pixel_index[16:0],
//           |                         | m_pixel_colour[15:0], m_status[1:0]
// APB cfg   | psel/penable/pwrite     | paddr[2:0], pwdata[31:0], prdata[31:0], pready
//
// One beat per cycle unless the queue is full; results are queued, then registered out.
// Front decodes each word as it is accepted (header checks, counters, row base add).
// Reset (aresetn low, synchronous) clears row state, config, queue and output valid.
// s_ready drops only while the result queue is full; output stalls fill the queue.
// Beats that raise no pixel write and no end marker produce no result.
module row_span_sprite_decoder_top #(
    parameter int FIFO_DEPTH = rssd_pkg::FIFO_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [15:0]                   s_data_word,
    input  logic                          s_end_of_data,
    // result stream
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_write_enable,
    output logic [16:0]                   m_pixel_index,
    output logic [15:0]                   m_pixel_colour,
    output logic [1:0]                    m_status,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rssd_pkg::PADDR_W-1:0]  paddr,
    input  logic [rssd_pkg::PDATA_W-1:0]  pwdata,
    output logic [rssd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import rssd_pkg::*;

    logic [15:0]   raw_width_reg;
    logic [15:0]   row_count_reg;
    logic          cfg_wr;

    logic          q_push, q_full, q_pop, q_not_empty;
    rssd_result_t  q_in, q_out, m_data;

    // Config registers: word select on paddr[2], low address bits ignored.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_width_reg <= '0;
            row_count_reg <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_RAW_WIDTH: raw_width_reg <= pwdata[15:0];
                REG_ROW_COUNT: row_count_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_RAW_WIDTH: prdata = {16'd0, raw_width_reg};
            REG_ROW_COUNT: prdata = {16'd0, row_count_reg};
            default:       prdata = '0;
        endcase
    end

    // Front: per-word decode and row bookkeeping.
    rssd_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_valid),
        .in_ready       (s_ready),
        .in_data_word   (s_data_word),
        .in_end_of_data (s_end_of_data),
        .raw_width      (raw_width_reg),
        .row_count      (row_count_reg),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (q_in)
    );

    // Result queue decouples the decoder from output backpressure.
    rssd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    // Back: registered output stage.
    rssd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_data    (m_data)
    );

    assign m_write_enable = m_data.write_enable;
    assign m_pixel_index  = m_data.pixel_index;
    assign m_pixel_colour = m_data.pixel_colour;
    assign m_status       = m_data.status;

endmodule

// File: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rssd_pkg::*;

    // ------------------------------------------------------------------
    // Run parameters
    // ------------------------------------------------------------------
    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 4;     // settle time after the last owed result
    localparam int HOLD_CYCLES    = 100;   // long output stall, fills the result queue
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either channel
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_BEATS   = 1750;
    localparam int QUIET_TAIL     = 300;   // final stretch runs with no idling at all

    // Register byte addresses: index 0 at 0, index 1 at 4.
    localparam logic [PADDR_W-1:0] ADDR_RAW_WIDTH = {REG_RAW_WIDTH, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_ROW_COUNT = {REG_ROW_COUNT, 2'b00};

    // Where the decoder stands within a row.
    typedef enum logic [1:0] {
        WANT_LEAD = 2'd0,   // transparent count
        WANT_LAST = 2'd1,   // last-pixel index
        IN_PIXELS = 2'd2
    } decode_phase_t;

    // ------------------------------------------------------------------
    // DUT inputs, all driven to known values from time zero
    // ------------------------------------------------------------------
    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [15:0]         s_data_word   = '0;
    logic                s_end_of_data = 1'b0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic                m_write_enable;
    logic [16:0]         m_pixel_index;
    logic [15:0]         m_pixel_colour;
    logic [1:0]          m_status;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [PADDR_W-1:0]  paddr         = '0;
    logic [PDATA_W-1:0]  pwdata        = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // ------------------------------------------------------------------
    // Shadow of the decoder: register copies and row state
    // ------------------------------------------------------------------
    logic [15:0]   cfg_raw_width = '0;
    logic [15:0]   cfg_row_count = '0;
    decode_phase_t phase         = WANT_LEAD;
    logic [15:0]   cur_row       = '0;
    logic [15:0]   row_base      = '0;
    logic [16:0]   column        = '0;
    logic [16:0]   pixels_left   = '0;
    logic [15:0]   lead_count    = '0;

    // Pixel writes and end-of-sprite reports still owed by the DUT, oldest first.
    rssd_result_t  writes_due[$];

    // Bookkeeping
    int  error_count       = 0;
    int  decoded_beats     = 0;  // every accepted input word, ignored ones included
    int  pixels_checked    = 0;
    int  sprites_done      = 0;
    int  sprites_truncated = 0;
    int  quiet_cycles      = 0;
    int  holds_asked       = 0;  // bumped by a test to request one long output stall
    bit  tx_idle           = 1'b1;
    bit  rx_idle           = 1'b1;

    row_span_sprite_decoder_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_word    (s_data_word),
        .s_end_of_data  (s_end_of_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_write_enable (m_write_enable),
        .m_pixel_index  (m_pixel_index),
        .m_pixel_colour (m_pixel_colour),
        .m_status       (m_status),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Decoder shadow
    // ------------------------------------------------------------------

    // Width rounded up to a multiple of four, wrapping at 16 bits.
    function automatic logic [15:0] eff_width();
        logic [15:0] padded;
        padded = cfg_raw_width + WIDTH_PAD;
        return padded & WIDTH_MASK;
    endfunction

    // Pixel words a header calls for; zero means the row is skipped
    // (explicit empty header or any bounds failure against the rounded width).
    function automatic logic [16:0] header_span(logic [15:0] lead, logic [15:0] last_idx);
        logic [15:0] w;
        w = eff_width();
        if ((lead == '0 && last_idx == EMPTY_LAST) || lead > w || lead > last_idx ||
            {1'b0, last_idx} + 17'd1 > {1'b0, w})
            return '0;
        return {1'b0, last_idx} + 17'd1 - {1'b0, lead};
    endfunction

    // Row done: base moves by the width in force right now.
    function automatic void close_row();
        cur_row     = cur_row + 16'd1;
        row_base    = row_base + eff_width();
        phase       = WANT_LEAD;
        column      = '0;
        pixels_left = '0;
    endfunction

    // Advance the shadow by one accepted word and queue what it should produce.
    function automatic void decode_word(logic [15:0] word, logic eod);
        rssd_result_t res;
        logic [16:0]  span;
        res = '0;
        decoded_beats++;
        if (cur_row < cfg_row_count) begin
            case (phase)
                WANT_LAST: begin
                    span = header_span(lead_count, word);
                    if (span == '0) begin
                        close_row();
                    end else begin
                        column      = {1'b0, lead_count};
                        pixels_left = span;
                        phase       = IN_PIXELS;
                    end
                end
                IN_PIXELS: begin
                    // key colours leave the pre-filled background alone
                    if (word != KEY_BLUE && word != KEY_GREEN) begin
                        res.write_enable = 1'b1;
                        res.pixel_index  = {1'b0, row_base} + column;
                        res.pixel_colour = word;
                    end
                    column      = column + 17'd1;
                    pixels_left = pixels_left - 17'd1;
                    if (pixels_left == '0)
                        close_row();
                end
                default: begin
                    lead_count = word;
                    phase      = WANT_LAST;
                end
            endcase
        end
        if (eod) begin
            if (cur_row >= cfg_row_count)
                res.status = STAT_DONE;
            else
                res.status = STAT_TRUNC;
            // rearm for the next sprite, registers kept
            phase       = WANT_LEAD;
            cur_row     = '0;
            row_base    = '0;
            column      = '0;
            pixels_left = '0;
            lead_count  = '0;
        end
        if (res.write_enable || eod)
            writes_due.push_back(res);
    endfunction

    function automatic void note_failure(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] %s", $time, msg);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One input beat. An idle burst may come first; valid stays high from
    // one beat to the next when there is none.
    task automatic send_word(input logic [15:0] word, input logic eod);
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_data_word   <= word;
        s_end_of_data <= eod;
        do @(posedge aclk); while (!s_ready);
        decode_word(word, eod);
    endtask

    // Stop sending, let every owed result arrive, then give the pipe SETTLE_CYCLES
    // of settle time for words that produce nothing.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (writes_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup, then access; lands on the edge with pready high.
    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= PDATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_RAW_WIDTH)
            cfg_raw_width = value;
        else
            cfg_row_count = value;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [15:0] raw_width, input logic [15:0] rows);
        wait_drained();
        write_reg(ADDR_RAW_WIDTH, raw_width);
        write_reg(ADDR_ROW_COUNT, rows);
    endtask

    function automatic logic [15:0] pick_colour();
        case ($urandom_range(0, 7))
            0:       return KEY_BLUE;
            1:       return KEY_GREEN;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly valid headers with short spans (keeps huge widths cheap),
    // plus empty, out-of-bounds and fully random ones.
    function automatic void pick_header(output logic [15:0] lead, output logic [15:0] last_idx);
        int wi;
        int sel;
        int hi;
        wi  = int'(eff_width());
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            lead     = '0;
            last_idx = EMPTY_LAST;
        end else if (sel == 1 || wi == 0) begin
            lead     = 16'($urandom);
            last_idx = 16'($urandom);
        end else if (sel == 2) begin
            lead     = 16'($urandom_range(0, wi + 2));
            last_idx = 16'($urandom_range(0, wi + 2));
        end else begin
            lead = 16'($urandom_range(0, wi - 1));
            hi   = wi - 1 - int'(lead);
            if (hi > 15)
                hi = 15;
            last_idx = lead + 16'($urandom_range(0, hi));
        end
    endfunction

    // Header plus the pixel words it calls for; 'close' puts the end marker
    // on the row's final word.
    task automatic send_row(input logic [15:0] lead, input logic [15:0] last_idx,
                            input bit close);
        logic [16:0] span;
        span = header_span(lead, last_idx);
        send_word(lead, 1'b0);
        send_word(last_idx, close && span == '0);
        for (int i = 0; i < span; i++)
            send_word(pick_colour(), close && i == span - 1);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Zero rows: complete from the start, everything but the marker ignored.
    task automatic test_empty_sprite();
        set_config(16'd0, 16'd0);
        send_word(16'h5A5A, 1'b0);
        send_word(16'hFFFF, 1'b1);
    endtask

    // Width 5 rounds to 8. Empty header, each bounds failure, one good row
    // with colour extremes and both keys, then words past the last row.
    task automatic test_header_cases();
        set_config(16'd5, 16'd5);
        send_row(16'd0, EMPTY_LAST, 1'b0);
        send_row(16'd5, 16'd3, 1'b0);     // lead beyond last index
        send_row(16'd0, 16'd8, 1'b0);     // last index runs off the row
        send_row(16'd9, 16'd9, 1'b0);     // lead beyond width
        send_word(16'd4, 1'b0);
        send_word(16'd7, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(KEY_BLUE, 1'b0);
        send_word(KEY_GREEN, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0000, 1'b0);        // past the last row: ignored
        send_word(16'h7FFF, 1'b0);
        send_word(16'h0001, 1'b1);
    endtask

    // Data ends in each place a row can be: lead word, last index, mid-pixels.
    task automatic test_truncation();
        set_config(16'd8, 16'd2);
        send_word(16'h0003, 1'b1);
        send_word(16'd0, 1'b0);
        send_word(16'd7, 1'b1);
        send_word(16'd0, 1'b0);
        send_word(16'd3, 1'b0);
        send_word(16'hABCD, 1'b1);        // pixel write and truncation in one beat
    endtask

    // Widest width, width change between rows, 16-bit base wrap, then a
    // raw width that rounds to zero with the largest row count.
    task automatic test_width_extremes();
        set_config(16'd65532, 16'd3);
        send_row(16'd65530, 16'd65531, 1'b0);
        set_config(16'd4, 16'd3);
        send_row(16'd0, 16'd3, 1'b0);     // base 65532
        send_row(16'd2, 16'd3, 1'b1);     // base wrapped to 0
        set_config(16'd65533, 16'd65535);
        send_row(16'd0, 16'd0, 1'b0);
        send_word(16'h8000, 1'b1);
    endtask

    // Receiver holds off while a full-width row streams in; queue fills
    // and the input side has to stall.
    task automatic test_output_stall();
        set_config(16'd32, 16'd1);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        holds_asked++;
        send_row(16'd0, 16'd31, 1'b1);
        wait_drained();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // Mostly well-formed sprites with random headers and colours; some pure
    // noise and some cut short. Registers change between sprites, except in
    // the final stretch, which streams without gaps.
    task automatic test_random_sprites();
        int          goal;
        int          kind;
        int          cut;
        bit          trail;
        logic [15:0] lead;
        logic [15:0] last_idx;
        logic [16:0] span;
        goal = decoded_beats + RANDOM_BEATS;
        while (decoded_beats < goal) begin
            if (goal - decoded_beats < QUIET_TAIL) begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end else begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            if (goal - decoded_beats >= QUIET_TAIL && $urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 9))
                    0:       set_config(16'($urandom_range(65520, 65535)),
                                        16'($urandom_range(0, 6)));
                    1:       set_config(16'd0, 16'($urandom_range(0, 6)));
                    default: set_config(16'($urandom_range(1, 40)),
                                        16'($urandom_range(0, 6)));
                endcase
            end
            kind = $urandom_range(0, 9);
            if (kind == 0 || cfg_row_count == '0) begin
                repeat ($urandom_range(0, 12)) send_word(16'($urandom), 1'b0);
                send_word(16'($urandom), 1'b1);
            end else if (kind == 1) begin
                // some whole rows, then one row cut off before its last word
                repeat ($urandom_range(0, cfg_row_count - 1)) begin
                    pick_header(lead, last_idx);
                    send_row(lead, last_idx, 1'b0);
                end
                pick_header(lead, last_idx);
                span = header_span(lead, last_idx);
                cut  = $urandom_range(0, span);
                for (int i = 0; i <= cut; i++)
                    send_word(i == 0 ? lead : (i == 1 ? last_idx : pick_colour()), i == cut);
            end else begin
                trail = ($urandom_range(0, 4) == 0);
                for (int r = 0; r < cfg_row_count; r++) begin
                    pick_header(lead, last_idx);
                    send_row(lead, last_idx, !trail && r == cfg_row_count - 1);
                end
                if (trail) begin
                    repeat ($urandom_range(1, 4)) send_word(16'($urandom), 1'b0);
                    send_word(16'($urandom), 1'b1);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: check each beat, then pick next cycle's ready
    // ------------------------------------------------------------------
    initial begin : result_sink
        int           stall_left;
        int           hold_left;
        int           holds_seen;
        rssd_result_t want;
        stall_left = 0;
        hold_left  = 0;
        holds_seen = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (writes_due.size() == 0) begin
                    note_failure($sformatf(
                        "result with nothing owed: we=%0b idx=%0d colour=%h status=%0d",
                        m_write_enable, m_pixel_index, m_pixel_colour, m_status));
                end else begin
                    want = writes_due.pop_front();
                    if (m_write_enable !== want.write_enable ||
                        m_pixel_index  !== want.pixel_index  ||
                        m_pixel_colour !== want.pixel_colour ||
                        m_status       !== want.status)
                        note_failure($sformatf({"result mismatch: expected we=%0b idx=%0d ",
                            "colour=%h status=%0d, got we=%0b idx=%0d colour=%h status=%0d"},
                            want.write_enable, want.pixel_index, want.pixel_colour,
                            want.status, m_write_enable, m_pixel_index, m_pixel_colour,
                            m_status));
                    if (want.write_enable)
                        pixels_checked++;
                    if (want.status == STAT_DONE)
                        sprites_done++;
                    else if (want.status == STAT_TRUNC)
                        sprites_truncated++;
                end
            end
            // a new stall request starts the long count here
            if (holds_seen != holds_asked) begin
                holds_seen = holds_asked;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (rx_idle && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 13);   // start a not-ready burst of random length
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long with no beat on either channel ends the run
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results still owed",
                     quiet_cycles, writes_due.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_sprite();
        test_header_cases();
        test_truncation();
        test_width_extremes();
        test_output_stall();
        test_random_sprites();

        wait_drained();
        $display("Covered %0d input words: %0d pixel writes, %0d sprites complete, %0d cut short.",
                 decoded_beats, pixels_checked, sprites_done, sprites_truncated);
        $display("Widths from zero to wrap, row counts 0..65535, one long output stall; %0d failures.",
                 error_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
